@@ rtl/core/rpn_pkg.sv @@
`default_nettype none
package rpn_pkg;
	localparam int unsigned StackDepthDef = 128;
	localparam int unsigned DataW = 64;
	localparam int unsigned OpW = 3;
	localparam int unsigned DepthOutW = 8;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5,
		OP_SHOW = 3'd6,
		OP_UNK  = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POPB,
		ST_RDB,
		ST_POPA,
		ST_RDA,
		ST_EXEC,
		ST_RUN,
		ST_FIN,
		ST_PUSH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic sat;
	} alu_stat_t;

	typedef struct packed {
		logic [DataW-1:0] shown_value;
		logic shown;
		logic underflow;
		logic full_drop;
		logic zero_divisor;
		logic saturated;
		logic unknown_op;
		logic [DepthOutW-1:0] depth_after;
	} result_t;

	typedef struct packed {
		op_t op;
		logic [DataW-1:0] number;
	} token_t;
endpackage
`default_nettype wire

@@ rtl/core/rpn_if.sv @@
`default_nettype none
interface rpn_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rpn_alu.sv @@
`default_nettype none
// bit-serial arithmetic: add/sub one bit a cycle, shift-add multiply, restoring divide
module rpn_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rpn_pkg::alu_cmd_t cmd,
	input  wire logic [rpn_pkg::DataW-1:0] a,
	input  wire logic [rpn_pkg::DataW-1:0] b,
	output rpn_pkg::alu_stat_t stat,
	output logic [rpn_pkg::DataW-1:0] res
);
	localparam int unsigned W = rpn_pkg::DataW;
	localparam int unsigned CntW = 7;

	rpn_pkg::op_t op_q;
	logic busy_q, done_q;
	logic [CntW-1:0] cnt_q;
	logic [W-1:0] x_q, y_q, acc_q, q_q;
	logic [W:0] rem_q;
	logic [W+1:0] hi_q;
	logic carry_q, negr_q, nega_q, big_q, sat_q;
	logic [W-1:0] ma, mb;
	logic [W:0] rem_sh, rem_sub;
	logic [W+1:0] hi_add;
	logic sbit, cout;
	logic [W-1:0] clamp_v;
	logic clamp_s;
	logic [W-1:0] mag;
	logic b_sign_q;
	logic [W-1:0] res_q;
	logic clamp_s_mul;
	logic [W-1:0] clamp_v_mul;

	assign ma = a[W-1] ? (~a + 1'b1) : a;
	assign mb = b[W-1] ? (~b + 1'b1) : b;
	assign {cout, sbit} = {1'b0, x_q[0]} + {1'b0, y_q[0] ^ (op_q == rpn_pkg::OP_SUB)}
		+ {1'b0, carry_q};
	assign rem_sh = {rem_q[W-1:0], x_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, y_q};
	assign hi_add = hi_q + (x_q[0] ? {2'b00, y_q} : '0);
	assign mag = (op_q == rpn_pkg::OP_MUL) ? {hi_q[W/2-1:0], acc_q[W-1:W/2]} : q_q;

	always_comb begin
		clamp_s = 1'b0;
		clamp_v = negr_q ? (~mag + 1'b1) : mag;
		if (negr_q) begin
			if (big_q || (mag[W-1] && mag[W-2:0] != '0)) begin
				clamp_s = 1'b1;
				clamp_v = {1'b1, {(W-1){1'b0}}};
			end
		end else if (big_q || mag[W-1]) begin
			clamp_s = 1'b1;
			clamp_v = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				unique case (op_q)
					rpn_pkg::OP_DIV: if (cnt_q == CntW'(W + W/2 - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					rpn_pkg::OP_MOD: if (cnt_q == CntW'(W - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: if (cnt_q == CntW'(W)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			carry_q <= (cmd.op == rpn_pkg::OP_SUB);
			nega_q <= a[W-1];
			negr_q <= a[W-1] ^ b[W-1];
			big_q <= 1'b0;
			sat_q <= 1'b0;
			rem_q <= '0;
			hi_q <= '0;
			acc_q <= '0;
			q_q <= '0;
			if (cmd.op == rpn_pkg::OP_ADD || cmd.op == rpn_pkg::OP_SUB) begin
				x_q <= a;
				y_q <= b;
			end else begin
				x_q <= (cmd.op == rpn_pkg::OP_MUL) ? ma : ma;
				y_q <= mb;
			end
		end else if (busy_q) begin
			unique case (op_q)
				rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
					if (cnt_q < CntW'(W)) begin
						acc_q <= {sbit, acc_q[W-1:1]};
						carry_q <= cout;
						x_q <= {1'b0, x_q[W-1:1]};
						y_q <= {1'b0, y_q[W-1:1]};
					end else begin
						// overflow check on final signs
						if (nega_q == (b_sign_q ^ (op_q == rpn_pkg::OP_SUB))
							&& acc_q[W-1] != nega_q) begin
							sat_q <= 1'b1;
							res_q <= nega_q ? {1'b1, {(W-1){1'b0}}}
								: {1'b0, {(W-1){1'b1}}};
						end else begin
							res_q <= acc_q;
						end
					end
				end
				rpn_pkg::OP_MUL: begin
					if (cnt_q < CntW'(W)) begin
						acc_q <= {hi_add[0], acc_q[W-1:1]};
						hi_q <= {1'b0, hi_add[W+1:1]};
						x_q <= {1'b0, x_q[W-1:1]};
					end else begin
						big_q <= hi_q[W-1:W/2] != '0;
						sat_q <= clamp_s_mul;
						res_q <= clamp_v_mul;
					end
				end
				rpn_pkg::OP_DIV: begin
					x_q <= {x_q[W-2:0], 1'b0};
					if (!rem_sub[W]) begin
						rem_q <= rem_sub;
						if (cnt_q < CntW'(W/2)) big_q <= 1'b1;
						else q_q <= {q_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						if (cnt_q >= CntW'(W/2)) q_q <= {q_q[W-2:0], 1'b0};
					end
				end
				default: begin
					x_q <= {x_q[W-2:0], 1'b0};
					rem_q <= rem_sub[W] ? rem_sh : rem_sub;
				end
			endcase
		end
	end

	always_ff @(posedge clk) if (cmd.start) b_sign_q <= b[W-1];

	// multiply clamp uses live high word as overflow source
	always_comb begin
		logic [W-1:0] m;
		logic bg;
		m = {hi_q[W/2-1:0], acc_q[W-1:W/2]};
		bg = hi_q[W+1:W/2] != '0;
		clamp_s_mul = 1'b0;
		clamp_v_mul = negr_q ? (~m + 1'b1) : m;
		if (negr_q) begin
			if (bg || (m[W-1] && m[W-2:0] != '0)) begin
				clamp_s_mul = 1'b1;
				clamp_v_mul = {1'b1, {(W-1){1'b0}}};
			end
		end else if (bg || m[W-1]) begin
			clamp_s_mul = 1'b1;
			clamp_v_mul = {1'b0, {(W-1){1'b1}}};
		end
	end

	logic [W-1:0] mod_v;
	assign mod_v = nega_q ? (~rem_q[W-1:0] + 1'b1) : rem_q[W-1:0];

	always_comb begin
		stat.busy = busy_q;
		stat.done = done_q;
		unique case (op_q)
			rpn_pkg::OP_DIV: begin
				res = clamp_v;
				stat.sat = clamp_s;
			end
			rpn_pkg::OP_MOD: begin
				res = mod_v;
				stat.sat = 1'b0;
			end
			default: begin
				res = res_q;
				stat.sat = sat_q;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/rpn_stack_evaluator_core.sv @@
`default_nettype none
// RPN evaluator over a stack of signed Q32.32 values held in a single-port memory.
// One result item per input item, one item at a time; a finished result waits in an
// output register while the next item is taken. Add, subtract and multiply use a
// bit-serial unit (one bit per cycle) plus stack access; modulo and divide use a
// restoring divider (one quotient bit per cycle). A result held back by the
// receiver stalls the next item only at its end. The stack memory needs no
// clearing after reset.
module rpn_stack_evaluator_core #(
	parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDef
) (
	input wire logic clk,
	input wire logic arst_n,
	rpn_if.sink   in_ch,
	rpn_if.source out_ch
);
	localparam int unsigned W = rpn_pkg::DataW;
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	rpn_pkg::state_t state_q, state_d;
	rpn_pkg::op_t op_q;
	logic [W-1:0] num_q, a_q, b_q, rd_q, push_v;
	logic [DW-1:0] depth_q;
	logic under_q, full_q, zd_q, sat_q, b_ok_q, a_ok_q;
	rpn_pkg::result_t res_q;
	logic out_v_q;
	logic [W-1:0] mem [STACK_DEPTH];
	logic we, re;
	logic [AW-1:0] addr;
	rpn_pkg::alu_cmd_t cmd;
	rpn_pkg::alu_stat_t st;
	logic [W-1:0] alu_res;
	logic [W-1:0] a_use, b_use;

	assign a_use = a_ok_q ? rd_q : '0;
	assign b_use = b_ok_q ? b_q : '0;

	rpn_alu u_alu (.clk(clk), .arst_n(arst_n), .cmd(cmd), .a(a_use), .b(b_use),
		.stat(st), .res(alu_res));

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= push_v;
		if (re) rd_q <= mem[addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpn_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				unique case (in_ch.data.op)
					rpn_pkg::OP_PUSH: state_d = rpn_pkg::ST_PUSH;
					rpn_pkg::OP_UNK:  state_d = rpn_pkg::ST_OUT;
					default:          state_d = rpn_pkg::ST_POPB;
				endcase
			end
			rpn_pkg::ST_POPB: state_d = rpn_pkg::ST_RDB;
			rpn_pkg::ST_RDB: begin
				if (op_q == rpn_pkg::OP_SHOW) state_d = rpn_pkg::ST_OUT;
				else if ((op_q == rpn_pkg::OP_DIV || op_q == rpn_pkg::OP_MOD)
					&& (!b_ok_q || rd_q == '0)) state_d = rpn_pkg::ST_OUT;
				else state_d = rpn_pkg::ST_POPA;
			end
			rpn_pkg::ST_POPA: state_d = rpn_pkg::ST_RDA;
			rpn_pkg::ST_RDA: state_d = rpn_pkg::ST_EXEC;
			rpn_pkg::ST_EXEC: state_d = rpn_pkg::ST_RUN;
			rpn_pkg::ST_RUN: if (st.done) state_d = rpn_pkg::ST_FIN;
			rpn_pkg::ST_FIN: state_d = rpn_pkg::ST_PUSH;
			rpn_pkg::ST_PUSH: state_d = rpn_pkg::ST_OUT;
			rpn_pkg::ST_OUT: if (!out_v_q || out_ch.ready) state_d = rpn_pkg::ST_IDLE;
			default: state_d = rpn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == rpn_pkg::ST_IDLE);
		cmd.start = (state_q == rpn_pkg::ST_EXEC);
		cmd.op = op_q;
		we = 1'b0;
		re = 1'b0;
		addr = AW'(depth_q - 1'b1);
		push_v = (op_q == rpn_pkg::OP_PUSH) ? num_q : a_q;
		unique case (state_q)
			rpn_pkg::ST_POPB, rpn_pkg::ST_POPA: re = (depth_q != '0);
			rpn_pkg::ST_PUSH: begin
				addr = AW'(depth_q);
				we = (DW'(STACK_DEPTH) != depth_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::ST_IDLE;
			depth_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpn_pkg::ST_OUT && state_d == rpn_pkg::ST_IDLE) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
			if ((state_q == rpn_pkg::ST_POPB || state_q == rpn_pkg::ST_POPA)
				&& depth_q != '0) depth_q <= depth_q - 1'b1;
			if (state_q == rpn_pkg::ST_PUSH && depth_q != DW'(STACK_DEPTH))
				depth_q <= depth_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rpn_pkg::ST_IDLE: begin
				op_q <= in_ch.data.op;
				num_q <= in_ch.data.number;
				under_q <= 1'b0;
				full_q <= 1'b0;
				zd_q <= 1'b0;
				sat_q <= 1'b0;
			end
			rpn_pkg::ST_POPB: begin
				b_ok_q <= depth_q != '0;
				if (depth_q == '0) under_q <= 1'b1;
			end
			rpn_pkg::ST_RDB: begin
				b_q <= rd_q;
				if ((op_q == rpn_pkg::OP_DIV || op_q == rpn_pkg::OP_MOD)
					&& (!b_ok_q || rd_q == '0)) zd_q <= 1'b1;
			end
			rpn_pkg::ST_POPA: begin
				a_ok_q <= depth_q != '0;
				if (depth_q == '0) under_q <= 1'b1;
			end
			rpn_pkg::ST_FIN: begin
				a_q <= alu_res;
				sat_q <= st.sat;
			end
			rpn_pkg::ST_PUSH: if (depth_q == DW'(STACK_DEPTH)) full_q <= 1'b1;
			default: ;
		endcase
		if (state_q == rpn_pkg::ST_OUT && state_d == rpn_pkg::ST_IDLE) begin
			res_q.shown <= (op_q == rpn_pkg::OP_SHOW);
			res_q.shown_value <= (op_q == rpn_pkg::OP_SHOW) ? b_use : '0;
			res_q.underflow <= under_q;
			res_q.full_drop <= full_q;
			res_q.zero_divisor <= zd_q;
			res_q.saturated <= sat_q;
			res_q.unknown_op <= (op_q == rpn_pkg::OP_UNK);
			res_q.depth_after <= rpn_pkg::DepthOutW'(depth_q);
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = res_q;

`ifndef SYNTH
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH)) else $error("stack depth beyond capacity");
	a_alu_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpn_pkg::ST_IDLE |-> !st.busy) else $error("alu busy while idle");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q) else $error("result item lost");
`endif
endmodule
`default_nettype wire

@@ sim/tb_rpn_checker.sv @@
module tb_rpn_checker (
	input wire logic clk,
	input wire logic arst_n,
	rpn_if in_ch,
	rpn_if out_ch,
	output int unsigned fails,
	output int unsigned pending,
	output int unsigned results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rpn_pkg::*;

	localparam logic [63:0] QMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] QMIN = 64'h8000_0000_0000_0000;

	logic [63:0] stack_mem [StackDepthDef];
	int unsigned depth;
	bit underflow_hit;
	bit full_hit;
	result_t expected_q [$];

	function automatic logic [63:0] pop_value();
		if (depth == 0) begin
			underflow_hit = 1;
			return 64'd0;
		end
		depth--;
		return stack_mem[depth];
	endfunction

	function automatic void push_value(logic [63:0] v);
		if (depth < StackDepthDef) begin
			stack_mem[depth] = v;
			depth++;
		end else begin
			full_hit = 1;
		end
	endfunction

	function automatic logic [63:0] abs64(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	function automatic logic [63:0] apply_sign(logic [127:0] m, bit neg, ref bit sat);
		if (neg) begin
			if (m > {64'd0, QMIN}) begin
				sat = 1;
				return QMIN;
			end
			return -m[63:0];
		end
		if (m > {64'd0, QMAX}) begin
			sat = 1;
			return QMAX;
		end
		return m[63:0];
	endfunction

	function automatic result_t evaluate(token_t t);
		result_t r;
		logic [63:0] a, b, s;
		logic [127:0] m;
		bit sat;
		r = '0;
		sat = 0;
		underflow_hit = 0;
		full_hit = 0;
		case (t.op)
			OP_PUSH: push_value(t.number);
			OP_ADD, OP_SUB: begin
				b = pop_value();
				a = pop_value();
				s = (t.op == OP_ADD) ? a + b : a - b;
				if (((t.op == OP_ADD) ? (a[63] == b[63]) : (a[63] != b[63]))
						&& s[63] != a[63]) begin
					sat = 1;
					s = a[63] ? QMIN : QMAX;
				end
				push_value(s);
			end
			OP_MUL: begin
				b = pop_value();
				a = pop_value();
				m = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> 32;
				push_value(apply_sign(m, a[63] ^ b[63], sat));
			end
			OP_DIV, OP_MOD: begin
				b = pop_value();
				if (b == 0) begin
					r.zero_divisor = 1;
				end else begin
					a = pop_value();
					if (t.op == OP_DIV) begin
						m = ({64'd0, abs64(a)} << 32) / {64'd0, abs64(b)};
						push_value(apply_sign(m, a[63] ^ b[63], sat));
					end else begin
						s = abs64(a) % abs64(b);
						push_value(a[63] ? -s : s);
					end
				end
			end
			OP_SHOW: begin
				r.shown_value = pop_value();
				r.shown = 1;
			end
			default: r.unknown_op = 1;
		endcase
		r.underflow = underflow_hit;
		r.full_drop = full_hit;
		r.saturated = sat;
		r.depth_after = depth[7:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e, g;
		if (!arst_n) begin
			depth = 0;
			fails <= 0;
			results_seen <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(evaluate(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				g = out_ch.data;
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, g);
					fails <= fails + 1;
				end else begin
					e = expected_q.pop_front();
					if (g !== e) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, g);
						fails <= fails + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rpn_pkg::*;

	logic clk;
	logic arst_n;
	int unsigned fails, pending, results_seen;
	int idle_in, stall_out;
	int sim_depth;

	rpn_if #(.T(token_t)) in_ch ();
	rpn_if #(.T(result_t)) out_ch ();

	rpn_stack_evaluator_core uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));
	tb_rpn_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fails(fails), .pending(pending), .results_seen(results_seen));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_out);

	function automatic logic [63:0] rand_num();
		case ($urandom_range(5))
			0: return 64'h7FFF_FFFF_FFFF_FFFF;
			1: return 64'h8000_0000_0000_0000;
			2: return 64'd0;
			3: return {{32{1'b0}}, 32'($urandom_range(7))} << 32;
			4: return {{40{$urandom_range(1) == 1}}, 24'($urandom)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send(op_t op, logic [63:0] n);
		if ($urandom_range(99) < idle_in) begin
			in_ch.valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_in) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= '{op: op, number: n};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		case (op)
			OP_PUSH: if (sim_depth < StackDepthDef) sim_depth++;
			OP_ADD, OP_SUB, OP_MUL, OP_SHOW: sim_depth = (sim_depth > 0) ? sim_depth - 1 : 0;
			OP_DIV, OP_MOD: sim_depth = (sim_depth > 1) ? sim_depth - 1 : 0;
			default: ;
		endcase
	endtask

	task automatic random_items(int count);
		op_t op;
		for (int i = 0; i < count; i++) begin
			if (sim_depth < 2 && $urandom_range(9) != 0) op = OP_PUSH;
			else if (sim_depth > 12 && $urandom_range(1) == 0) op = OP_SHOW;
			else op = op_t'($urandom_range(7));
			send(op, rand_num());
		end
	endtask

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		idle_in = 0;
		stall_out = 0;
		sim_depth = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty-stack cases
		send(OP_SHOW, '0);
		send(OP_ADD, '0);
		send(OP_DIV, '0);
		send(OP_MOD, '0);
		send(OP_UNK, '1);
		// saturation at both ends, a signed modulo and a zero divisor
		send(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
		send(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
		send(OP_ADD, '0);
		send(OP_PUSH, 64'h8000_0000_0000_0000);
		send(OP_SUB, '0);
		send(OP_PUSH, 64'h8000_0000_0000_0000);
		send(OP_MUL, '0);
		send(OP_PUSH, 64'h0000_0000_0000_0001);
		send(OP_DIV, '0);
		send(OP_PUSH, 64'hFFFF_FFFD_8000_0000);
		send(OP_PUSH, 64'h0000_0002_0000_0000);
		send(OP_MOD, '0);
		send(OP_SHOW, '0);
		send(OP_PUSH, '0);
		send(OP_DIV, '0);
		send(OP_SHOW, '0);
		// fill to overflow
		for (int i = 0; i < StackDepthDef + 2; i++) send(OP_PUSH, rand_num());
		for (int i = 0; i < StackDepthDef + 1; i++) send(OP_SHOW, '0);

		idle_in = 0;  stall_out = 0;  random_items(380);
		idle_in = 84; stall_out = 0;  random_items(380);
		idle_in = 0;  stall_out = 84; random_items(380);
		idle_in = 37; stall_out = 37; random_items(380);
		in_ch.valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("drove every opcode, empty and full stack, saturation and zero divisors");
		$display("%0d results checked", results_seen);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
